// File: hdl/mrbf_pkg.sv
// ----------------------------------------------------------------------------
// mrbf_pkg: shared types and constants for the broadcast FIFO
// Sizes, command and register codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package mrbf_pkg;

  localparam int unsigned Depth      = 1024;
  localparam int unsigned DataWidth  = 64;
  localparam int unsigned MaxReaders = 8;

  localparam int unsigned AddrWidth   = $clog2(Depth);
  localparam int unsigned CountWidth  = $clog2(Depth + 1);
  localparam int unsigned ReaderWidth = 3;
  localparam int unsigned NrWidth     = 4;
  localparam int unsigned CapWidth    = 11;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [NrWidth-1:0]  ReadersReset  = NrWidth'(1);
  localparam logic [CapWidth-1:0] CapacityReset = CapWidth'(1024);

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ACTIVE_READERS = 2'd0,
    CFG_CAPACITY       = 2'd1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

// File: hdl/mrbf_controller.sv
// ----------------------------------------------------------------------------
// mrbf_controller: sequencing of one beat through the datapath
// Takes a beat in idle, executes it in the execute state once the result
// register is free, and owns the output valid flag.
// ----------------------------------------------------------------------------
module mrbf_controller
  import mrbf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mrbf_pkg::ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    in_stall_o    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.execute = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.execute) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/mrbf_datapath.sv
// ----------------------------------------------------------------------------
// mrbf_datapath: ring storage, reader counters and result register
// Holds config, ring memory, write and read positions, unread counts.
// ----------------------------------------------------------------------------
module mrbf_datapath
  import mrbf_pkg::*;
(
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mrbf_pkg::ctrl_cmd_t                 cmd_i,
  input  logic                                cfg_we_i,
  input  logic [mrbf_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [31:0]                         cfg_data_i,
  input  logic [1:0]                          command_i,
  input  logic [mrbf_pkg::DataWidth-1:0]      push_data_i,
  input  logic [mrbf_pkg::ReaderWidth-1:0]    reader_index_i,
  output logic                                success_o,
  output logic [mrbf_pkg::DataWidth-1:0]      read_data_o,
  output logic                                reader_empty_o,
  output logic                                reader_full_o,
  output logic                                queue_full_o
);

  logic [NrWidth-1:0]     readers_q;
  logic [CapWidth-1:0]    capacity_q;
  logic [NrWidth-1:0]     nr_eff;
  logic [CountWidth-1:0]  cap_eff;

  logic [DataWidth-1:0]   mem [Depth];
  logic [DataWidth-1:0]   rdata_q;

  cmd_e                   cmd_q;
  logic [DataWidth-1:0]   data_q;
  logic [ReaderWidth-1:0] rd_q;

  logic [AddrWidth-1:0]   wpos_q, wpos_d;
  logic [AddrWidth-1:0]   pos_q [MaxReaders];
  logic [AddrWidth-1:0]   pos_d [MaxReaders];
  logic [CountWidth-1:0]  cnt_q [MaxReaders];
  logic [CountWidth-1:0]  cnt_d [MaxReaders];

  logic full_now, full_next, rd_active, push_ok, read_ok, pop_ok;

  function automatic logic [AddrWidth-1:0] advance(input logic [AddrWidth-1:0] pos,
                                                   input logic [CountWidth-1:0] cap);
    logic [CountWidth-1:0] nxt;
    nxt = CountWidth'(pos) + CountWidth'(1);
    return (nxt >= cap) ? '0 : nxt[AddrWidth-1:0];
  endfunction

  // clamp out-of-range register values
  always_comb begin
    if (readers_q == '0) nr_eff = NrWidth'(1);
    else if (readers_q > NrWidth'(MaxReaders)) nr_eff = NrWidth'(MaxReaders);
    else nr_eff = readers_q;
    if (capacity_q == '0) cap_eff = CountWidth'(1);
    else if (capacity_q > CapWidth'(Depth)) cap_eff = CountWidth'(Depth);
    else cap_eff = CountWidth'(capacity_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      readers_q  <= ReadersReset;
      capacity_q <= CapacityReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ACTIVE_READERS: readers_q  <= cfg_data_i[NrWidth-1:0];
        CFG_CAPACITY:       capacity_q <= cfg_data_i[CapWidth-1:0];
        default: ;
      endcase
    end
  end

  // capture the beat and read the reader's head
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= cmd_e'(command_i);
      data_q  <= push_data_i;
      rd_q    <= reader_index_i;
      rdata_q <= mem[pos_q[reader_index_i]];
    end
    if (cmd_i.execute && push_ok) mem[wpos_q] <= data_q;
  end

  always_comb begin
    full_now = 1'b0;
    for (int r = 0; r < MaxReaders; r++) begin
      if (NrWidth'(r) < nr_eff && cnt_q[r] >= cap_eff) full_now = 1'b1;
    end
    rd_active = NrWidth'(rd_q) < nr_eff;
    push_ok   = (cmd_q == CMD_PUSH) && !full_now;
    read_ok   = (cmd_q == CMD_POP || cmd_q == CMD_PEEK) && rd_active && (cnt_q[rd_q] != '0);
    pop_ok    = read_ok && (cmd_q == CMD_POP);

    wpos_d = push_ok ? advance(wpos_q, cap_eff) : wpos_q;
    for (int r = 0; r < MaxReaders; r++) begin
      cnt_d[r] = cnt_q[r];
      pos_d[r] = pos_q[r];
      if (push_ok && NrWidth'(r) < nr_eff) cnt_d[r] = cnt_q[r] + CountWidth'(1);
      if (pop_ok && ReaderWidth'(r) == rd_q) begin
        cnt_d[r] = cnt_q[r] - CountWidth'(1);
        pos_d[r] = advance(pos_q[r], cap_eff);
      end
    end

    full_next = 1'b0;
    for (int r = 0; r < MaxReaders; r++) begin
      if (NrWidth'(r) < nr_eff && cnt_d[r] >= cap_eff) full_next = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
      for (int r = 0; r < MaxReaders; r++) begin
        pos_q[r] <= '0;
        cnt_q[r] <= '0;
      end
    end else if (cmd_i.execute) begin
      wpos_q <= wpos_d;
      for (int r = 0; r < MaxReaders; r++) begin
        pos_q[r] <= pos_d[r];
        cnt_q[r] <= cnt_d[r];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      success_o      <= push_ok || read_ok;
      read_data_o    <= read_ok ? rdata_q : '0;
      reader_empty_o <= rd_active ? (cnt_d[rd_q] == '0) : 1'b1;
      reader_full_o  <= rd_active && (cnt_d[rd_q] >= cap_eff);
      queue_full_o   <= full_next;
    end
  end

endmodule

// File: hdl/multi_reader_broadcast_fifo_unit.sv
// ----------------------------------------------------------------------------
// multi_reader_broadcast_fifo_unit: single-writer, multi-reader ring buffer
// One writer, up to eight readers, each with its own read position.
// ----------------------------------------------------------------------------
// Each input beat is a push, a pop or a peek and yields one result beat.
// A beat is accepted in the idle state, which also issues the registered
// ring read at the reader's head; the execute state then updates the
// positions and unread counts and loads the result register. A new beat
// is not accepted until the previous one has executed.
// A finished result waits in its own register, so the next beat is accepted
// while the previous result is still stalled; execution only holds when the
// result register is still occupied. Configuration writes are always taken
// (ready is tied high) and must only happen while the block is idle. The
// ring needs no clearing after reset: counts and positions reset to zero.
// ----------------------------------------------------------------------------
module multi_reader_broadcast_fifo_unit
  import mrbf_pkg::*;
(
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input beats
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       command_i,
  input  logic [mrbf_pkg::DataWidth-1:0]   push_data_i,
  input  logic [mrbf_pkg::ReaderWidth-1:0] reader_index_i,
  // result beats
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             success_o,
  output logic [mrbf_pkg::DataWidth-1:0]   read_data_o,
  output logic                             reader_empty_o,
  output logic                             reader_full_o,
  output logic                             queue_full_o,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mrbf_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);

  ctrl_cmd_t ctrl_cmd;

  // Always ready: writes land in the register file directly.
  assign cfg_ready_o = 1'b1;

  // Sequence each beat: capture, then execute when the result slot frees.
  mrbf_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (ctrl_cmd)
  );

  // Ring, per-reader counters and the result register.
  mrbf_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .command_i      (command_i),
    .push_data_i    (push_data_i),
    .reader_index_i (reader_index_i),
    .success_o      (success_o),
    .read_data_o    (read_data_o),
    .reader_empty_o (reader_empty_o),
    .reader_full_o  (reader_full_o),
    .queue_full_o   (queue_full_o)
  );

endmodule

// File: dv/mrbf_tb_pkg.sv
// ----------------------------------------------------------------------------
// mrbf_tb_pkg: result prediction and checking for the broadcast FIFO bench
// Keeps a private copy of the ring, positions, counts and registers, works
// out the result beat of every accepted command and compares result beats.
// ----------------------------------------------------------------------------
package mrbf_tb_pkg;

  import mrbf_pkg::*;

  typedef struct packed {
    logic                 success;
    logic [DataWidth-1:0] read_data;
    logic                 reader_empty;
    logic                 reader_full;
    logic                 queue_full;
  } fifo_status_t;

  class broadcast_fifo_checker;

    logic [DataWidth-1:0] ring_mem [Depth];
    bit                   written [Depth];
    int unsigned          wr_pos;
    int unsigned          rd_pos [MaxReaders];
    int unsigned          unread [MaxReaders];
    logic [NrWidth-1:0]   readers_reg;
    logic [CapWidth-1:0]  cap_reg;
    fifo_status_t         expected_status_q [$];
    int unsigned          errors;

    function new();
      foreach (ring_mem[i]) begin
        ring_mem[i] = '0;
        written[i]  = 1'b0;
      end
      foreach (rd_pos[r]) begin
        rd_pos[r] = 0;
        unread[r] = 0;
      end
      wr_pos      = 0;
      readers_reg = ReadersReset;
      cap_reg     = CapacityReset;
      errors      = 0;
    endfunction

    // Out-of-range register values are clamped into the legal range.
    function int unsigned live_readers();
      if (readers_reg == 0) return 1;
      if (readers_reg > MaxReaders) return MaxReaders;
      return readers_reg;
    endfunction

    function int unsigned live_capacity();
      if (cap_reg == 0) return 1;
      if (cap_reg > Depth) return Depth;
      return cap_reg;
    endfunction

    function int unsigned step_pos(int unsigned p, int unsigned cap);
      return (p + 1 >= cap) ? 0 : p + 1;
    endfunction

    function bit any_reader_full(int unsigned nr, int unsigned cap);
      for (int unsigned r = 0; r < nr; r++) begin
        if (unread[r] >= cap) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void write_register(logic [CfgIdxWidth-1:0] idx, logic [31:0] value);
      if (idx == CFG_ACTIVE_READERS) readers_reg = value[NrWidth-1:0];
      else if (idx == CFG_CAPACITY) cap_reg = value[CapWidth-1:0];
    endfunction

    // False when a pop or peek by this reader would hit a never-written entry.
    function bit head_defined(int unsigned rd);
      if (rd >= live_readers() || unread[rd] == 0) return 1'b1;
      return written[rd_pos[rd] % Depth];
    endfunction

    function fifo_status_t predict_step(cmd_e cmd, logic [DataWidth-1:0] data,
                                        int unsigned rd);
      int unsigned          nr;
      int unsigned          cap;
      bit                   served;
      bit                   ok;
      logic [DataWidth-1:0] rdata;
      fifo_status_t         res;
      nr     = live_readers();
      cap    = live_capacity();
      served = rd < nr;
      ok     = 1'b0;
      rdata  = '0;
      case (cmd)
        CMD_PUSH: begin
          if (!any_reader_full(nr, cap)) begin
            ring_mem[wr_pos % Depth] = data;
            written[wr_pos % Depth]  = 1'b1;
            wr_pos = step_pos(wr_pos, cap);
            for (int unsigned r = 0; r < nr; r++) unread[r]++;
            ok = 1'b1;
          end
        end
        CMD_POP, CMD_PEEK: begin
          if (served && unread[rd] != 0) begin
            rdata = ring_mem[rd_pos[rd] % Depth];
            if (cmd == CMD_POP) begin
              rd_pos[rd] = step_pos(rd_pos[rd], cap);
              unread[rd]--;
            end
            ok = 1'b1;
          end
        end
        default: ;
      endcase
      res.success      = ok;
      res.read_data    = ok ? rdata : '0;
      res.reader_empty = served ? (unread[rd] == 0) : 1'b1;
      res.reader_full  = served ? (unread[rd] >= cap) : 1'b0;
      res.queue_full   = any_reader_full(nr, cap);
      return res;
    endfunction

    function void note_request(cmd_e cmd, logic [DataWidth-1:0] data, int unsigned rd);
      expected_status_q.push_back(predict_step(cmd, data, rd));
    endfunction

    function int unsigned pending();
      return expected_status_q.size();
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_result(fifo_status_t got);
      fifo_status_t want;
      if (expected_status_q.size() == 0) begin
        report_mismatch("result beat with no command outstanding");
        return;
      end
      want = expected_status_q.pop_front();
      if (got.success !== want.success)
        report_mismatch($sformatf("success got %b want %b", got.success, want.success));
      if (got.read_data !== want.read_data)
        report_mismatch($sformatf("read_data got %h want %h", got.read_data,
                                  want.read_data));
      if (got.reader_empty !== want.reader_empty)
        report_mismatch($sformatf("reader_empty got %b want %b", got.reader_empty,
                                  want.reader_empty));
      if (got.reader_full !== want.reader_full)
        report_mismatch($sformatf("reader_full got %b want %b", got.reader_full,
                                  want.reader_full));
      if (got.queue_full !== want.queue_full)
        report_mismatch($sformatf("queue_full got %b want %b", got.queue_full,
                                  want.queue_full));
    endtask

  endclass

endpackage

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for multi_reader_broadcast_fifo_unit
// Drives push, pop and peek beats with random gaps and result stalls, walks
// the reader count and capacity through several settings, and checks every
// result beat against a cycle-free prediction of the ring and its readers.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import mrbf_pkg::*;
  import mrbf_tb_pkg::*;

  // Register indexes past the end of the register list; writes must be ignored.
  localparam logic [CfgIdxWidth-1:0] CfgIdxSpareLo = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgIdxSpareHi = 2'd3;

  localparam int unsigned NumPhases     = 10;
  localparam int unsigned BeatsPerPhase = 113;
  localparam int unsigned TailCycles    = 20;
  localparam int unsigned CycleLimit    = 200000;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_stall_o;
  logic [1:0]             command_i      = CMD_NONE;
  logic [DataWidth-1:0]   push_data_i    = '0;
  logic [ReaderWidth-1:0] reader_index_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i    = 1'b0;
  logic                   success_o;
  logic [DataWidth-1:0]   read_data_o;
  logic                   reader_empty_o;
  logic                   reader_full_o;
  logic                   queue_full_o;
  logic                   cfg_valid_i    = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i    = '0;
  logic [31:0]            cfg_data_i     = '0;

  broadcast_fifo_checker sb = new();

  // Upper bounds of the per-beat idle draws; zero gives a stretch with no gaps.
  int unsigned max_in_gap  = 5;
  int unsigned max_out_gap = 5;
  int unsigned out_hold    = 0;
  int unsigned cycle_count = 0;
  fifo_status_t seen_status;

  int unsigned phase_readers [NumPhases] = '{8, 3, 15, 2, 0, 8, 5, 4, 1, 8};
  int unsigned phase_cap     [NumPhases] = '{1024, 2, 7, 2047, 5, 16, 1, 64, 3, 1024};

  multi_reader_broadcast_fifo_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .push_data_i    (push_data_i),
    .reader_index_i (reader_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .success_o      (success_o),
    .read_data_o    (read_data_o),
    .reader_empty_o (reader_empty_o),
    .reader_full_o  (reader_full_o),
    .queue_full_o   (queue_full_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Result side: check every beat taken, then draw the stall for the next one.
  // The stall only counts down while a result is actually offered, so the
  // gap always lands on a waiting beat.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (!out_stall_i) begin
        seen_status.success      = success_o;
        seen_status.read_data    = read_data_o;
        seen_status.reader_empty = reader_empty_o;
        seen_status.reader_full  = reader_full_o;
        seen_status.queue_full   = queue_full_o;
        sb.compare_result(seen_status);
        out_hold = $urandom_range(0, max_out_gap);
      end else if (out_hold != 0) begin
        out_hold--;
      end
      out_stall_i <= (out_hold != 0);
    end
  end

  // Offer one command beat after a random gap and hold it until taken.
  // Valid stays high on return so a zero-gap beat can follow back to back;
  // callers that stop sending lower it themselves.
  task automatic send_beat(input cmd_e cmd, input logic [DataWidth-1:0] data,
                           input logic [ReaderWidth-1:0] rd);
    int unsigned gap;
    gap = $urandom_range(0, max_in_gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    push_data_i    <= data;
    reader_index_i <= rd;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(cmd, data, rd);
  endtask

  // Stop sending and hold until every outstanding result beat has come back.
  task automatic settle_queue();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write one register; bits outside mask get random junk the block must drop.
  task automatic write_cfg(input logic [CfgIdxWidth-1:0] idx, input logic [31:0] value,
                           input logic [31:0] mask);
    logic [31:0] word;
    word = ($urandom & ~mask) | (value & mask);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, word);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One random command. Most pops and peeks go to active readers; a pop or
  // peek that would land on a never-written ring entry turns into a push.
  task automatic random_beat(input int unsigned push_pct);
    int unsigned            roll;
    int unsigned            nr;
    cmd_e                   cmd;
    logic [DataWidth-1:0]   data;
    logic [ReaderWidth-1:0] rd;
    nr   = sb.live_readers();
    roll = $urandom_range(0, 99);
    data = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: data = '0;
      1: data = '1;
      default: ;
    endcase
    rd = ReaderWidth'($urandom_range(0, MaxReaders - 1));
    if ($urandom_range(0, 9) < 8) rd = ReaderWidth'($urandom_range(0, nr - 1));
    if (roll < 3) cmd = CMD_NONE;
    else if (roll < 3 + push_pct) cmd = CMD_PUSH;
    else cmd = ($urandom_range(0, 3) == 0) ? CMD_PEEK : CMD_POP;
    if ((cmd == CMD_POP || cmd == CMD_PEEK) && !sb.head_defined(rd)) cmd = CMD_PUSH;
    send_beat(cmd, data, rd);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting, one reader: extreme data, empty refusals, inactive
    // readers, and the unused command.
    send_beat(CMD_PUSH, '1, 0);
    send_beat(CMD_PUSH, '0, 7);
    send_beat(CMD_PEEK, '0, 0);
    send_beat(CMD_POP, '0, 0);
    send_beat(CMD_POP, '0, 0);
    send_beat(CMD_POP, '1, 0);
    send_beat(CMD_PEEK, '0, 0);
    send_beat(CMD_POP, '0, 7);
    send_beat(CMD_PEEK, '0, 4);
    send_beat(CMD_NONE, '1, 0);
    send_beat(CMD_PUSH, {1'b1, {(DataWidth-1){1'b0}}}, 0);
    send_beat(CMD_POP, '0, 0);
    settle_queue();

    // All eight readers, capacity 0 (acts as one), plus writes to the
    // indexes past the register list.
    write_cfg(CFG_ACTIVE_READERS, 32'd8, 32'hF);
    write_cfg(CfgIdxSpareLo, '0, '0);
    write_cfg(CfgIdxSpareHi, '0, '0);
    write_cfg(CFG_CAPACITY, 32'd0, 32'h7FF);

    // One push fills every reader; the next is refused while any reader lags.
    send_beat(CMD_PUSH, 64'h5A5A_A5A5_0F0F_F0F0, 1);
    send_beat(CMD_PUSH, 64'h1, 2);
    send_beat(CMD_PEEK, '0, 7);
    send_beat(CMD_POP, '0, 0);
    send_beat(CMD_PUSH, '1, 0);
    send_beat(CMD_NONE, '0, 3);
    send_beat(CMD_POP, '0, 5);
    settle_queue();

    // Random phases, each with its own setting and idle profile.
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      int unsigned push_pct;
      write_cfg(CFG_ACTIVE_READERS, phase_readers[ph], 32'hF);
      write_cfg(CFG_CAPACITY, phase_cap[ph], 32'h7FF);
      max_in_gap  = ($urandom_range(0, 3) == 0) ? 0 : 5;
      max_out_gap = ($urandom_range(0, 3) == 0) ? 0 : 5;
      push_pct    = $urandom_range(30, 70);
      for (int unsigned i = 0; i < BeatsPerPhase; i++) begin
        // Halfway through, pause until the block has handed back everything.
        if (i == BeatsPerPhase / 2) settle_queue();
        random_beat(push_pct);
      end
      settle_queue();
    end

    // Let any stray result beat show up before the verdict.
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/mrbf_pkg.sv
hdl/mrbf_controller.sv
hdl/mrbf_datapath.sv
hdl/multi_reader_broadcast_fifo_unit.sv
dv/mrbf_tb_pkg.sv
dv/tb_top.sv
